[rtl/smx_pkg.sv]
// Shared types, codes and widths of the stack machine executor.
// No dependencies; every other file imports this package.
package smx_pkg;

    localparam int OPCODE_W = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int SKIP_W   = 31;

    localparam int DEF_MEMORY_WORDS = 16;
    localparam int DEF_STACK_DEPTH  = 64;

    // Instruction opcodes
    localparam logic [OPCODE_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_NOR   = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_IFZ   = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_STORE = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_POP   = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_PUSHI = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_NOOP  = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_HALT  = 4'd8;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HALT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd5;

    // Decoded instruction as held in the queue
    typedef struct packed {
        logic [OPCODE_W-1:0]      op;        // unused codes folded to NOOP
        logic signed [DATA_W-1:0] operand;
        logic [1:0]               min_depth; // words needed on the stack
        logic                     skip_arm;  // operand is strictly positive
    } instr_t;

endpackage

[rtl/smx_if.sv]
// Handshake interfaces for the command and response channels.
// Depends on smx_pkg for field widths.
interface smx_cmd_if import smx_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [DATA_W-1:0]   operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface smx_rsp_if import smx_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   top_value;
    logic [COUNT_W-1:0]         stack_count;

    modport source (output valid, output status, output top_value, output stack_count,
                    input ready);
    modport sink   (input valid, input status, input top_value, input stack_count,
                    output ready);
endinterface

[rtl/smx_front.sv]
// Front end: accepts commands and decodes them into queue entries.
// Depends on smx_pkg and smx_cmd_if.
module smx_front import smx_pkg::*;
(
    smx_cmd_if.sink   cmd,
    input  logic      clearing,
    input  logic      q_full,
    output logic      q_push,
    output instr_t    q_data
);

    assign cmd.ready = !q_full && !clearing;
    assign q_push    = cmd.valid && cmd.ready;

    always_comb
    begin
        q_data.operand  = cmd.operand;
        q_data.skip_arm = !cmd.operand[DATA_W-1] && (cmd.operand != '0);
        q_data.op       = (cmd.opcode > OP_HALT) ? OP_NOOP : cmd.opcode;
        unique case (cmd.opcode) inside
            OP_ADD, OP_NOR, OP_STORE:
                q_data.min_depth = 2'd2;
            OP_IFZ, OP_LOAD, OP_POP:
                q_data.min_depth = 2'd1;
            default:
                q_data.min_depth = 2'd0;
        endcase
    end

endmodule

[rtl/smx_queue.sv]
// Two-entry queue between front and back end.
// Depends on smx_pkg for the entry type.
module smx_queue import smx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  instr_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output instr_t head_data
);

    instr_t      entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/smx_back.sv]
// Back end: executes queued instructions on the stack and data memory.
// Depends on smx_pkg and smx_rsp_if; holds both memories and the result register.
module smx_back import smx_pkg::*;
#(
    parameter int MEMORY_WORDS = DEF_MEMORY_WORDS,
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  instr_t     q_data,
    output logic       q_pop,
    output logic       clearing,
    smx_rsp_if.source  rsp
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int MA_W = $clog2(MEMORY_WORDS);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_WAIT2 = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [DATA_W-1:0]   tos_reg, tos_next;
    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic                halted_reg, halted_next;
    logic [OPCODE_W-1:0] op_reg, op_next;
    logic [MA_W-1:0]     clr_idx_reg, clr_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_top_reg, out_top_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    // Stack below the top word, and data memory
    logic [DATA_W-1:0]   stk_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   stk_rd_reg;
    logic                stk_we, stk_re;
    logic [SA_W-1:0]     stk_waddr, stk_raddr;
    logic [DATA_W-1:0]   stk_wdata;

    logic [DATA_W-1:0]   dm_mem [MEMORY_WORDS];
    logic [DATA_W-1:0]   dm_rd_reg;
    logic                dm_we, dm_re;
    logic [MA_W-1:0]     dm_waddr, dm_raddr;
    logic [DATA_W-1:0]   dm_wdata;

    logic                slot_free;
    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic [SP_W-1:0]     sp_m1, sp_m2, sp_m3;
    logic                bad_addr;
    logic [SP_W+COUNT_W-1:0] count_wide;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign sp_m1     = sp_reg - SP_W'(1);
    assign sp_m2     = sp_reg - SP_W'(2);
    assign sp_m3     = sp_reg - SP_W'(3);
    assign bad_addr  = (tos_reg >= DATA_W'(MEMORY_WORDS));
    assign clearing  = (state_reg == S_CLEAR);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.top_value   = out_top_reg;
    assign rsp.stack_count = out_count_reg;

    always_comb
    begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        tos_next     = tos_reg;
        skip_next    = skip_reg;
        halted_next  = halted_reg;
        op_next      = op_reg;
        clr_idx_next = clr_idx_reg;
        q_pop        = 1'b0;
        fin          = 1'b0;
        fin_status   = ST_OK;
        stk_we       = 1'b0;
        stk_waddr    = sp_m1[SA_W-1:0];
        stk_wdata    = tos_reg;
        stk_re       = 1'b0;
        stk_raddr    = sp_m2[SA_W-1:0];
        dm_we        = 1'b0;
        dm_waddr     = tos_reg[MA_W-1:0];
        dm_wdata     = stk_rd_reg;
        dm_re        = 1'b0;
        dm_raddr     = tos_reg[MA_W-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                dm_we        = 1'b1;
                dm_waddr     = clr_idx_reg;
                dm_wdata     = '0;
                clr_idx_next = clr_idx_reg + MA_W'(1);
                if (clr_idx_reg == MA_W'(MEMORY_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (halted_reg)
                    begin
                        fin_status = ST_HALT;
                        fin        = slot_free;
                    end
                    else if (skip_reg != '0)
                    begin
                        fin_status = ST_SKIP;
                        fin        = slot_free;
                        if (slot_free)
                        begin
                            skip_next = skip_reg - SKIP_W'(1);
                        end
                    end
                    else if (sp_reg < SP_W'(q_data.min_depth))
                    begin
                        fin_status = ST_UNDER;
                        fin        = slot_free;
                    end
                    else if (q_data.op == OP_PUSHI && sp_reg == SP_W'(STACK_DEPTH))
                    begin
                        fin_status = ST_OVER;
                        fin        = slot_free;
                    end
                    else if ((q_data.op == OP_LOAD || q_data.op == OP_STORE) && bad_addr)
                    begin
                        fin_status = ST_BADADDR;
                        fin        = slot_free;
                    end
                    else
                    begin
                        unique case (q_data.op)
                            OP_ADD, OP_NOR, OP_STORE:
                            begin
                                // fetch the word below the top, finish in S_WAIT (STORE may go on to S_WAIT2)
                                stk_re     = 1'b1;
                                q_pop      = 1'b1;
                                op_next    = q_data.op;
                                state_next = S_WAIT;
                            end
                            OP_IFZ, OP_POP:
                            begin
                                if (sp_reg >= SP_W'(2))
                                begin
                                    stk_re     = 1'b1;
                                    q_pop      = 1'b1;
                                    op_next    = q_data.op;
                                    state_next = S_WAIT;
                                end
                                else
                                begin
                                    fin = slot_free;
                                    if (slot_free)
                                    begin
                                        sp_next = '0;
                                    end
                                end
                                if (q_data.op == OP_IFZ && tos_reg == '0 && q_data.skip_arm
                                    && (q_pop || slot_free))
                                begin
                                    skip_next = q_data.operand[SKIP_W-1:0];
                                end
                            end
                            OP_LOAD:
                            begin
                                dm_re      = 1'b1;
                                q_pop      = 1'b1;
                                op_next    = q_data.op;
                                state_next = S_WAIT;
                            end
                            OP_PUSHI:
                            begin
                                fin = slot_free;
                                if (slot_free)
                                begin
                                    // spill the old top into the stack memory
                                    stk_we   = (sp_reg != '0);
                                    tos_next = q_data.operand;
                                    sp_next  = sp_reg + SP_W'(1);
                                end
                            end
                            OP_HALT:
                            begin
                                fin_status = ST_HALT;
                                fin        = slot_free;
                                if (slot_free)
                                begin
                                    halted_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                fin = slot_free;
                            end
                        endcase
                    end
                    if (fin)
                    begin
                        q_pop = 1'b1;
                    end
                end
            end

            S_WAIT:
            begin
                unique case (op_reg)
                    OP_ADD, OP_NOR:
                    begin
                        fin = slot_free;
                        if (slot_free)
                        begin
                            tos_next = (op_reg == OP_ADD) ? (tos_reg + stk_rd_reg)
                                                          : ~(tos_reg | stk_rd_reg);
                            sp_next  = sp_m1;
                        end
                    end
                    OP_LOAD:
                    begin
                        fin = slot_free;
                        if (slot_free)
                        begin
                            tos_next = dm_rd_reg;
                        end
                    end
                    OP_STORE:
                    begin
                        if (sp_reg >= SP_W'(3))
                        begin
                            // write the value and fetch the new top
                            dm_we      = 1'b1;
                            stk_re     = 1'b1;
                            stk_raddr  = sp_m3[SA_W-1:0];
                            state_next = S_WAIT2;
                        end
                        else
                        begin
                            fin = slot_free;
                            if (slot_free)
                            begin
                                dm_we   = 1'b1;
                                sp_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        // IFZ and POP: the fetched word becomes the top
                        fin = slot_free;
                        if (slot_free)
                        begin
                            tos_next = stk_rd_reg;
                            sp_next  = sp_m1;
                        end
                    end
                endcase
                if (fin)
                begin
                    state_next = S_IDLE;
                end
            end

            S_WAIT2:
            begin
                fin = slot_free;
                if (slot_free)
                begin
                    tos_next   = stk_rd_reg;
                    sp_next    = sp_m2;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_wide      = {{COUNT_W{1'b0}}, sp_next};
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_top_next    = out_top_reg;
        out_count_next  = out_count_reg;
        if (fin)
        begin
            out_valid_next  = 1'b1;
            out_status_next = fin_status;
            out_top_next    = (sp_next != '0) ? tos_next : '0;
            out_count_next  = count_wide[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sp_reg        <= '0;
            tos_reg       <= '0;
            skip_reg      <= '0;
            halted_reg    <= 1'b0;
            op_reg        <= OP_NOOP;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            tos_reg       <= tos_next;
            skip_reg      <= skip_next;
            halted_reg    <= halted_next;
            op_reg        <= op_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_top_reg    <= out_top_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        if (dm_re)
        begin
            dm_rd_reg <= dm_mem[dm_raddr];
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!q_pop && !fin))
        else $error("instruction taken during memory clear");

    a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && fin_status == ST_SKIP) |=> (skip_reg == $past(skip_reg) - SKIP_W'(1)))
        else $error("skip counter did not step down");

endmodule

[rtl/stack_machine_executor.sv]
// Flow: a command transfer is written into the queue, then executed by the back end into
// the result register. PUSHI, NOOP, HALT, faulted, skipped or halted items and IFZ/POP
// on a one-word stack finish from S_IDLE; ADD, NOR, LOAD, other IFZ/POP and a STORE that
// empties the stack also pass S_WAIT; other STOREs pass S_WAIT and S_WAIT2, set by the
// registered reads of the stack and data memories. Reset: control state clears at once,
// then a pass over the data memory zeroes it, during which cmd.ready stays low.
module stack_machine_executor import smx_pkg::*;
#(
    parameter int MEMORY_WORDS = DEF_MEMORY_WORDS,
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    smx_cmd_if.sink   cmd,
    smx_rsp_if.source rsp
);

    // Front to queue
    logic   q_push;
    logic   q_full;
    instr_t q_in;

    // Queue to back end
    logic   q_valid;
    logic   q_pop;
    instr_t q_head;

    // Back end busy zeroing the data memory after reset
    logic   clearing;

    // Decode each command transfer; hold off transfers while the queue is full
    // or the data memory is being cleared.
    smx_front u_front (
        .cmd      (cmd),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // Short queue so the front keeps taking commands while the back end is
    // busy with a multi-cycle instruction or stalled on the response side.
    smx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // Execute on the operand stack (top word in a register, the rest in a
    // memory) and the data memory; the result register parts the back end
    // from the response channel so the next item can start while a result
    // waits for its transfer.
    smx_back #(
        .MEMORY_WORDS (MEMORY_WORDS),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule
